// ===== hdl/vaenv_pkg.sv =====
// ----------------------------------------------------------------------------
// vaenv_pkg
// Shared widths, codes and types of the voice amplitude envelope core.
// ----------------------------------------------------------------------------
package vaenv_pkg;

  localparam int LEVEL_W  = 24;
  localparam int DUR_W    = 20;
  localparam int PCT_W    = 7;
  localparam int OP_W     = 2;
  localparam int VOICE_W  = 5;
  localparam int STAGE_W  = 3;
  localparam int CFG_IDX_W = 8;
  localparam int NUM_W    = PCT_W + LEVEL_W - 1;

  localparam int VOICES_DEF = 32;
  localparam int FAST_RELEASE_DEF = 128;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(24'h800000);
  localparam logic [PCT_W-1:0]   PCT_MAX    = PCT_W'(100);

  localparam logic [DUR_W-1:0] ATTACK_RST  = DUR_W'(4410);
  localparam logic [DUR_W-1:0] DECAY_RST   = DUR_W'(4410);
  localparam logic [DUR_W-1:0] RELEASE_RST = DUR_W'(4410);
  localparam logic [PCT_W-1:0] SUSTAIN_RST = PCT_W'(100);

  localparam logic [STAGE_W-1:0] ST_OFF     = 3'd0;
  localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
  localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
  localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
  localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;
  localparam logic [STAGE_W-1:0] ST_FAST    = 3'd5;

  localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;
  localparam logic [OP_W-1:0] OP_FAST_OFF = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 8'd3;

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] step;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DUR_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== hdl/vaenv_div.sv =====
// ----------------------------------------------------------------------------
// vaenv_div
// Bit-serial restoring divider: one quotient bit per cycle, shifted into the
// numerator register as the numerator bits leave it.
// ----------------------------------------------------------------------------
module vaenv_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vaenv_pkg::div_req_t req_i,
  output vaenv_pkg::div_rsp_t rsp_o
);

  localparam int NW    = vaenv_pkg::NUM_W;
  localparam int DW    = vaenv_pkg::DUR_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NW-1:0]     num_q;
  logic [DW-1:0]     den_q;
  logic [DW-1:0]     rem_q;
  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic              ge;
  logic [DW-1:0]     rem_d;

  assign trial = {rem_q, num_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};
  assign rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");

endmodule

// ===== hdl/voice_amplitude_adsr_envelope_core.sv =====
// ----------------------------------------------------------------------------
// voice_amplitude_adsr_envelope_core
// Linear ADSR amplitude envelopes for a bank of voices held in a voice store.
// ----------------------------------------------------------------------------
// An item that needs no new step is read from the store (S_READ), and its result
// is loaded out from S_DONE; the next item is accepted back in S_IDLE. Note-on
// of a voice in range, note-off or fast note-off of a sounding voice and a tick
// entering decay first run the bit-serial divider (S_DIV). A stalled result holds
// the next item once it is ready; a sustain write holds the input off while its
// level is divided. Reset clears all voices at once through valid bits.
module voice_amplitude_adsr_envelope_core #(
  parameter int VOICES               = vaenv_pkg::VOICES_DEF,
  parameter int FAST_RELEASE_SAMPLES = vaenv_pkg::FAST_RELEASE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // voice[4:0]
  input  logic [vaenv_pkg::OP_W-1:0]      s_axis_tuser,  // operation[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [vaenv_pkg::LEVEL_W-1:0]   m_axis_tdata,  // level[23:0]
  output logic [vaenv_pkg::STAGE_W-1:0]   m_axis_tuser,  // stage[2:0]
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vaenv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vaenv_pkg::DUR_W-1:0]     cfg_data_i
);

  localparam int LW    = vaenv_pkg::LEVEL_W;
  localparam int DW    = vaenv_pkg::DUR_W;
  localparam int PW    = vaenv_pkg::PCT_W;
  localparam int NW    = vaenv_pkg::NUM_W;
  localparam int SW    = vaenv_pkg::STAGE_W;
  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int XW    = (VIDX_W > vaenv_pkg::VOICE_W) ? VIDX_W : vaenv_pkg::VOICE_W;
  localparam logic [DW-1:0] FAST_DEN = DW'(FAST_RELEASE_SAMPLES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_SUS  = 3'd4;

  logic [2:0]  state_q, state_d;

  logic [DW-1:0] attack_q, decay_q, release_q;
  logic [PW-1:0] sustain_q;
  logic          sus_dirty_q;
  logic [LW-1:0] sus_q;

  vaenv_pkg::entry_t mem [VOICES];
  logic [VOICES-1:0] vld_q;
  vaenv_pkg::entry_t rd_q;
  logic              rd_vld_q;
  vaenv_pkg::entry_t cur;
  vaenv_pkg::entry_t nxt;
  vaenv_pkg::entry_t res_q;

  logic [vaenv_pkg::OP_W-1:0] op_q;
  logic [VIDX_W-1:0]          addr_q;
  logic                       in_range_q;
  logic [XW-1:0]              voice_x;
  logic                       in_accept;
  logic                       cfg_we;

  logic [LW:0]   att_sum;
  logic          need_div;
  logic [LW-1:0] div_base;
  logic [DW-1:0] div_den;
  logic [DW-1:0] attack_eff, decay_eff, release_eff;
  logic [PW-1:0] pct_sat;
  logic          sus_start, item_start;
  logic          out_load;
  logic          out_vld_q;
  logic [LW-1:0] out_level_q;
  logic [SW-1:0] out_stage_q;

  vaenv_pkg::div_req_t div_req;
  vaenv_pkg::div_rsp_t div_rsp;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q    <= vaenv_pkg::ATTACK_RST;
      decay_q     <= vaenv_pkg::DECAY_RST;
      release_q   <= vaenv_pkg::RELEASE_RST;
      sustain_q   <= vaenv_pkg::SUSTAIN_RST;
      sus_dirty_q <= 1'b0;
      sus_q       <= vaenv_pkg::FULL_SCALE;
    end else begin
      if (sus_start) begin
        sus_dirty_q <= 1'b0;
      end
      if (state_q == S_SUS && div_rsp.done) begin
        sus_q <= div_rsp.quo[LW-1:0];
      end
      if (cfg_we) begin
        unique case (cfg_index_i)
          vaenv_pkg::CFG_ATTACK:  attack_q  <= cfg_data_i;
          vaenv_pkg::CFG_DECAY:   decay_q   <= cfg_data_i;
          vaenv_pkg::CFG_RELEASE: release_q <= cfg_data_i;
          vaenv_pkg::CFG_SUSTAIN: begin
            sustain_q   <= cfg_data_i[PW-1:0];
            sus_dirty_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign attack_eff  = (attack_q == '0) ? DW'(1) : attack_q;
  assign decay_eff   = (decay_q == '0) ? DW'(1) : decay_q;
  assign release_eff = (release_q == '0) ? DW'(1) : release_q;
  assign pct_sat     = (sustain_q > vaenv_pkg::PCT_MAX) ? vaenv_pkg::PCT_MAX : sustain_q;

  assign s_axis_tready = (state_q == S_IDLE) && !sus_dirty_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign voice_x       = XW'(s_axis_tdata[vaenv_pkg::VOICE_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q       <= s_axis_tuser;
      addr_q     <= voice_x[VIDX_W-1:0];
      in_range_q <= 32'(s_axis_tdata[vaenv_pkg::VOICE_W-1:0]) < 32'(VOICES);
      rd_q       <= mem[voice_x[VIDX_W-1:0]];
    end
    if (out_load && in_range_q) begin
      mem[addr_q] <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (in_accept) begin
        rd_vld_q <= vld_q[voice_x[VIDX_W-1:0]];
      end
      if (out_load && in_range_q) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

  assign cur     = rd_vld_q ? rd_q : '0;
  assign att_sum = {1'b0, cur.level} + {1'b0, cur.step};

  always_comb begin
    nxt      = cur;
    need_div = 1'b0;
    div_base = '0;
    div_den  = DW'(1);
    unique case (op_q)
      vaenv_pkg::OP_TICK: begin
        case (cur.stage) inside
          vaenv_pkg::ST_ATTACK: begin
            if (att_sum >= {1'b0, vaenv_pkg::FULL_SCALE}) begin
              nxt.level = vaenv_pkg::FULL_SCALE;
              nxt.stage = vaenv_pkg::ST_DECAY;
              need_div  = 1'b1;
              div_base  = vaenv_pkg::FULL_SCALE - sus_q;
              div_den   = decay_eff;
            end else begin
              nxt.level = att_sum[LW-1:0];
            end
          end
          vaenv_pkg::ST_DECAY: begin
            if (cur.level <= sus_q || (cur.level - sus_q) <= cur.step) begin
              nxt.level = sus_q;
              nxt.stage = vaenv_pkg::ST_SUSTAIN;
            end else begin
              nxt.level = cur.level - cur.step;
            end
          end
          vaenv_pkg::ST_RELEASE, vaenv_pkg::ST_FAST: begin
            if (cur.step >= cur.level) begin
              nxt.level = '0;
              nxt.stage = vaenv_pkg::ST_OFF;
            end else begin
              nxt.level = cur.level - cur.step;
            end
          end
          default: ;
        endcase
      end
      vaenv_pkg::OP_NOTE_ON: begin
        nxt.level = '0;
        nxt.stage = vaenv_pkg::ST_ATTACK;
        need_div  = 1'b1;
        div_base  = vaenv_pkg::FULL_SCALE;
        div_den   = attack_eff;
      end
      vaenv_pkg::OP_NOTE_OFF: begin
        if (cur.stage != vaenv_pkg::ST_OFF) begin
          nxt.stage = vaenv_pkg::ST_RELEASE;
          need_div  = 1'b1;
          div_base  = cur.level;
          div_den   = release_eff;
        end
      end
      vaenv_pkg::OP_FAST_OFF: begin
        if (cur.stage != vaenv_pkg::ST_OFF) begin
          nxt.stage = vaenv_pkg::ST_FAST;
          need_div  = 1'b1;
          div_base  = cur.level;
          div_den   = FAST_DEN;
        end
      end
      default: ;
    endcase
  end

  assign sus_start  = (state_q == S_IDLE) && sus_dirty_q;
  assign item_start = (state_q == S_READ) && in_range_q && need_div;

  always_comb begin
    div_req.start = sus_start || item_start;
    if (sus_start) begin
      div_req.num = {pct_sat, {(LW-1){1'b0}}};
      div_req.den = DW'(100);
    end else begin
      div_req.num = NW'(div_base) + NW'(div_den) - NW'(1);
      div_req.den = div_den;
    end
  end

  vaenv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_load = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (sus_start) begin
          state_d = S_SUS;
        end else if (in_accept) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = item_start ? S_DIV : S_DONE;
      S_DIV:  if (div_rsp.done) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      S_SUS:  if (div_rsp.done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      res_q <= in_range_q ? nxt : '0;
    end else if (state_q == S_DIV && div_rsp.done) begin
      res_q.step <= div_rsp.quo[LW-1:0];
    end
    if (out_load) begin
      out_level_q <= res_q.level;
      out_stage_q <= res_q.stage;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_level_q;
  assign m_axis_tuser  = out_stage_q;

  a_result_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= vaenv_pkg::FULL_SCALE) &&
                      (m_axis_tuser <= vaenv_pkg::ST_FAST))
    else $error("result level or stage out of range");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_READ)
    else $error("accepted item did not start a store read");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV) || (state_q == S_SUS))
    else $error("divider finished with nobody waiting");

endmodule
